### rtl/adcsf_pkg.sv
package adcsf_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SAMPLE_W   = 8;
    localparam int FILL_W     = 9;

    typedef enum logic {
        OP_XFER = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef struct packed {
        logic                wr_en;
        logic [PTR_W-1:0]    wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [PTR_W-1:0]    rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] spi_reply;
        logic                sample_taken;
        logic                full_flag;
        logic [FILL_W-1:0]   fill_level;
    } result_t;

endpackage

### rtl/adcsf_mem.sv
module adcsf_mem
    import adcsf_pkg::*;
(
    input  logic                aclk,
    input  mem_req_t            req,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] store_reg [FIFO_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            store_reg[req.wr_addr] <= req.wr_data;
        end
    end

    // hold the last dequeued sample until the next read
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= store_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/adcsf_ctrl.sv
module adcsf_ctrl
    import adcsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic                opcode,
    input  logic [SAMPLE_W-1:0] adc_value,
    input  logic                adc_ready,
    input  logic [SAMPLE_W-1:0] rd_data,
    output mem_req_t            mem_req,
    output result_t             result
);

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             parity_reg, parity_next;
    logic             mark_reg, mark_next;
    logic             pend_valid_reg, pend_valid_next;

    logic             is_tick;
    logic             pop;
    logic             take;
    logic             push;
    logic [SAMPLE_W-1:0] pend_sample;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign is_tick = (opcode_t'(opcode) == OP_TICK);
    assign pop     = fire && !is_tick && (count_reg != '0);
    assign take    = fire && is_tick && !parity_reg && adc_ready;
    assign push    = take && (count_reg != CNT_W'(FIFO_DEPTH));

    // code 0 is reserved for a declined request
    assign pend_sample = !pend_valid_reg ? '0 :
                         (rd_data == '0) ? SAMPLE_W'(1) : rd_data;

    always_comb begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        count_next      = count_reg;
        parity_next     = parity_reg;
        mark_next       = mark_reg;
        pend_valid_next = pend_valid_reg;
        if (fire && is_tick) begin
            parity_next = !parity_reg;
        end
        if (push) begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            count_next  = count_reg + CNT_W'(1);
            mark_next   = 1'b0;
        end else if (take) begin
            mark_next = 1'b1;
        end
        if (pop) begin
            rd_ptr_next     = ptr_inc(rd_ptr_reg);
            count_next      = count_reg - CNT_W'(1);
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            parity_reg     <= 1'b0;
            mark_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            parity_reg     <= parity_next;
            mark_reg       <= mark_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_comb begin
        mem_req.wr_en   = push;
        mem_req.wr_addr = wr_ptr_reg;
        mem_req.wr_data = adc_value;
        mem_req.rd_en   = pop;
        mem_req.rd_addr = rd_ptr_reg;
    end

    always_comb begin
        result.spi_reply    = pop ? pend_sample : '0;
        result.sample_taken = take;
        result.full_flag    = mark_next;
        result.fill_level   = FILL_W'(count_next);
    end

endmodule

### rtl/adc_sample_fifo_spi_slave_core.sv
// The result of an accepted request is registered and shown on the m_ side in the cycle after it is taken.
// Throughput: one request per cycle while m_ready frees the output; the FIFO store takes one push or one pop a cycle.
// A single output register with pass-through ready decouples the two sides.
// Reset (aresetn low, synchronous) empties the FIFO and clears parity and full flag;
// the sample store itself is not cleared.
module adc_sample_fifo_spi_slave_core
    import adcsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [SAMPLE_W-1:0] s_adc_value,
    input  logic                s_adc_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_spi_reply,
    output logic                m_sample_taken,
    output logic                m_full_flag,
    output logic [FILL_W-1:0]   m_fill_level
);

    logic                fire;
    mem_req_t            mem_req;
    result_t             result;
    logic [SAMPLE_W-1:0] rd_data;
    logic                m_valid_reg, m_valid_next;
    result_t             out_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    adcsf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .opcode    (s_opcode),
        .adc_value (s_adc_value),
        .adc_ready (s_adc_ready),
        .rd_data   (rd_data),
        .mem_req   (mem_req),
        .result    (result)
    );

    adcsf_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // load a new result only when the request is taken
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_spi_reply    = out_reg.spi_reply;
    assign m_sample_taken = out_reg.sample_taken;
    assign m_full_flag    = out_reg.full_flag;
    assign m_fill_level   = out_reg.fill_level;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fill_level <= FILL_W'(FIFO_DEPTH)))
        else $error("fill level beyond FIFO depth");

    a_reply_not_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sample_taken) |-> (m_spi_reply == '0))
        else $error("reply on a tick");

    a_drop_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sample_taken && m_full_flag) |-> (m_fill_level == FILL_W'(FIFO_DEPTH)))
        else $error("sample dropped while FIFO not full");

    a_stall_only_when_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a held result");
`endif

endmodule

### sim/tb_top.sv
module tb_top;
    import adcsf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct {
        opcode_t             op;
        logic [SAMPLE_W-1:0] value;
        logic                conv_done;
        bit                  hold;
    } sample_req_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_opcode = 1'b0;
    logic [SAMPLE_W-1:0] s_adc_value = '0;
    logic                s_adc_ready = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [SAMPLE_W-1:0] m_spi_reply;
    logic                m_sample_taken;
    logic                m_full_flag;
    logic [FILL_W-1:0]   m_fill_level;

    adc_sample_fifo_spi_slave_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_adc_value    (s_adc_value),
        .s_adc_ready    (s_adc_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_spi_reply    (m_spi_reply),
        .m_sample_taken (m_sample_taken),
        .m_full_flag    (m_full_flag),
        .m_fill_level   (m_fill_level)
    );

    // FIFO mirror
    logic [SAMPLE_W-1:0] mirror_store [FIFO_DEPTH];
    logic [PTR_W-1:0]    mirror_wr_ptr = '0;
    logic [PTR_W-1:0]    mirror_rd_ptr = '0;
    logic [FILL_W-1:0]   mirror_held = '0;
    logic [SAMPLE_W-1:0] mirror_pending = '0;
    logic                mirror_parity = 1'b0;
    logic                mirror_overflow = 1'b0;

    sample_req_t pending_reqs[$];
    result_t     expected_results[$];
    sample_req_t driven_req;

    int cyc = 0;
    int n_errors = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_taken = 0;
    int n_dropped = 0;
    int n_declined = 0;
    int peak_fill = 0;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic result_t advance_fifo(input sample_req_t r);
        result_t             res;
        logic [SAMPLE_W-1:0] head;
        res = '0;
        if (r.op == OP_XFER) begin
            if (mirror_held != 0) begin
                res.spi_reply = mirror_pending;
                head = mirror_store[mirror_rd_ptr];
                // keep zero free to mean declined
                mirror_pending = (head == 0) ? SAMPLE_W'(1) : head;
                mirror_rd_ptr = wrap_inc(mirror_rd_ptr);
                mirror_held = mirror_held - FILL_W'(1);
            end
            if (res.spi_reply == 0)
                n_declined++;
        end else begin
            mirror_parity = ~mirror_parity;
            if (mirror_parity && r.conv_done) begin
                res.sample_taken = 1'b1;
                n_taken++;
                if (mirror_held < FIFO_DEPTH) begin
                    mirror_store[mirror_wr_ptr] = r.value;
                    mirror_wr_ptr = wrap_inc(mirror_wr_ptr);
                    mirror_held = mirror_held + FILL_W'(1);
                    mirror_overflow = 1'b0;
                end else begin
                    mirror_overflow = 1'b1;
                    n_dropped++;
                end
            end
        end
        res.full_flag = mirror_overflow;
        res.fill_level = mirror_held;
        if (int'(mirror_held) > peak_fill)
            peak_fill = int'(mirror_held);
        return res;
    endfunction

    task automatic add_req(input opcode_t op, input int value, input bit conv_done,
                           input bit hold);
        sample_req_t r;
        r.op = op;
        r.value = SAMPLE_W'(value);
        r.conv_done = conv_done;
        r.hold = hold;
        pending_reqs.push_back(r);
    endtask

    task automatic add_burst(input int n, input int tick_pct, input int ready_pct,
                             input bit hold_first);
        opcode_t op;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(99) < tick_pct) ? OP_TICK : OP_XFER;
            add_req(op, $urandom_range(255), $urandom_range(99) < ready_pct,
                    hold_first && i == 0);
        end
    endtask

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // quiet window: no idling on either side
    function automatic bit idle_now();
        return (cyc < 250 || cyc >= 650) && ($urandom_range(99) < 11);
    endfunction

    always @(posedge aclk) begin : drive_requests
        bit send;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(advance_fifo(driven_req));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                send = 1'b0;
                if (pending_reqs.size() != 0 && !idle_now()) begin
                    // hold a marked request until every result is back
                    if (!pending_reqs[0].hold || expected_results.size() == 0)
                        send = 1'b1;
                end
                if (send) begin
                    driven_req = pending_reqs.pop_front();
                    s_opcode <= driven_req.op;
                    s_adc_value <= driven_req.value;
                    s_adc_ready <= driven_req.conv_done;
                end
                s_valid <= send;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !idle_now();
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_spi_reply, m_sample_taken, m_full_flag, m_fill_level};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result reply %0d taken %0d full %0d fill %0d",
                         $time, got.spi_reply, got.sample_taken, got.full_flag,
                         got.fill_level);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                if (got !== want) begin
                    $display("%0t: mismatch expected %p, actual %p", $time, want, got);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        // empty transfer, then odd/even ticks with and without a conversion
        add_req(OP_XFER, 8'hA5, 1'b1, 1'b0);
        add_req(OP_TICK, 8'h00, 1'b1, 1'b0);
        add_req(OP_TICK, 8'h55, 1'b1, 1'b0);
        add_req(OP_TICK, 8'hFF, 1'b0, 1'b0);
        add_req(OP_TICK, 8'h12, 1'b0, 1'b0);
        add_req(OP_TICK, 8'hFF, 1'b1, 1'b0);
        add_req(OP_TICK, 8'h34, 1'b1, 1'b0);
        add_req(OP_TICK, 8'h80, 1'b1, 1'b0);
        // first pop after reset is declined although data is held
        add_req(OP_XFER, 8'h00, 1'b0, 1'b0);
        add_req(OP_XFER, 8'hFF, 1'b1, 1'b0);
        add_req(OP_XFER, 8'h7F, 1'b0, 1'b0);
        add_req(OP_XFER, 8'h01, 1'b1, 1'b0);
        add_req(OP_TICK, 8'h01, 1'b1, 1'b0);
        add_req(OP_TICK, 8'hFE, 1'b1, 1'b0);
        add_req(OP_XFER, 8'h00, 1'b0, 1'b0);
        add_req(OP_XFER, 8'h00, 1'b0, 1'b0);
        add_req(OP_TICK, 8'h00, 1'b0, 1'b0);
        add_req(OP_TICK, 8'hAA, 1'b1, 1'b0);
        add_req(OP_XFER, 8'hFF, 1'b1, 1'b0);

        add_burst(40, 60, 75, 1'b0);
        // fill to overflow so the write pointer wraps, then drain part way
        add_burst(540, 100, 100, 1'b1);
        add_burst(50, 3, 50, 1'b1);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (m_valid) begin
            $display("%0t: result left on output after drain", $time);
            n_errors++;
        end

        $display("requests %0d, results checked %0d, mismatches %0d",
                 n_accepted, n_checked, n_errors);
        $display("samples taken %0d, dropped on full %0d, declined replies %0d, peak fill %0d",
                 n_taken, n_dropped, n_declined, peak_fill);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### adc_sample_fifo_spi_slave_core.f
rtl/adcsf_pkg.sv
rtl/adcsf_mem.sv
rtl/adcsf_ctrl.sv
rtl/adc_sample_fifo_spi_slave_core.sv
sim/tb_top.sv
